[rtl/core/prqs_pkg.sv]
package prqs_pkg;

  // Field widths of the request and response words.
  localparam int IDX_W  = 8;
  localparam int PRIO_W = 5;

  // Sizing of the task table and of the priority levels.
  localparam int TASK_SLOTS      = 256;
  localparam int PRIORITY_LEVELS = 32;
  localparam int NUM_LEVELS      = 2 ** PRIO_W;
  localparam int NUM_SLOTS       = 2 ** IDX_W;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_DROP     = 2'd2
  } op_t;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PRIO_W-1:0] prio_t;

endpackage

[rtl/core/priority_ready_queue_scheduler_core.sv]
// A word accepted on the request side waits in the request register, is processed from there, and
// its response word is registered in the response register. Throughput: one request word per cycle
// while the response side does not stall; the per-task link table is a memory with a registered
// read, and the link of a new queue head is fetched in the background while the next word runs.
// Reset: every level is empty, no task is active and all links read as zero straight away.
module priority_ready_queue_scheduler_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               opcode,
  input  logic [prqs_pkg::IDX_W-1:0]  task_index,
  input  logic [prqs_pkg::PRIO_W-1:0] priority_req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic                     picked,
  output logic [prqs_pkg::IDX_W-1:0]  chosen_index,
  output logic [prqs_pkg::PRIO_W-1:0] chosen_priority
);

  localparam int IDX_W      = prqs_pkg::IDX_W;
  localparam int PRIO_W     = prqs_pkg::PRIO_W;
  localparam int NUM_LEVELS = prqs_pkg::NUM_LEVELS;
  localparam int NUM_SLOTS  = prqs_pkg::NUM_SLOTS;

  // Request register.
  logic                  req_full;
  logic [1:0]            req_op;
  prqs_pkg::idx_t        req_idx;
  prqs_pkg::prio_t       req_prio;

  // Queue state. hlink holds the link of each level's head, so a pop never waits on the memory.
  prqs_pkg::idx_t        head [NUM_LEVELS];
  prqs_pkg::idx_t        tail [NUM_LEVELS];
  prqs_pkg::idx_t        hlink [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] mask;
  logic                  act_valid;
  prqs_pkg::idx_t        act_index;
  prqs_pkg::prio_t       act_prio;
  prqs_pkg::idx_t        act_link;

  prqs_pkg::idx_t        head_next [NUM_LEVELS];
  prqs_pkg::idx_t        tail_next [NUM_LEVELS];
  prqs_pkg::idx_t        hlink_next [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] mask_next;
  logic                  act_valid_next;
  prqs_pkg::idx_t        act_index_next;
  prqs_pkg::prio_t       act_prio_next;
  prqs_pkg::idx_t        act_link_next;

  // Link memory with one valid bit per entry; an invalid entry reads as zero.
  prqs_pkg::idx_t        link_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  link_valid;
  logic [NUM_SLOTS-1:0]  link_valid_next;
  prqs_pkg::idx_t        rd_data;
  logic                  rd_valid;

  // A head link fetched last cycle, with any write of that cycle to the same entry.
  logic                  pend;
  prqs_pkg::prio_t       pend_lv;
  logic                  fwd_hit;
  prqs_pkg::idx_t        fwd_val;

  logic                  wr_en;
  prqs_pkg::idx_t        wr_addr;
  prqs_pkg::idx_t        wr_data;
  logic                  clr_en;
  prqs_pkg::idx_t        clr_addr;
  logic                  rd_issue;
  prqs_pkg::idx_t        rd_addr;
  prqs_pkg::prio_t       rd_lv;
  logic                  fwd_hit_next;
  prqs_pkg::idx_t        fwd_val_next;

  // Response register.
  logic                  out_full;
  logic                  out_picked;
  prqs_pkg::idx_t        out_index;
  prqs_pkg::prio_t       out_prio;

  logic                  res_picked;
  prqs_pkg::idx_t        res_index;
  prqs_pkg::prio_t       res_prio;

  logic                  can_load;
  logic                  proc;
  logic                  push_ok;
  prqs_pkg::idx_t        enq_idx;
  prqs_pkg::prio_t       enq_lv;
  prqs_pkg::idx_t        tl;
  prqs_pkg::prio_t       lv;
  prqs_pkg::idx_t        hd;
  prqs_pkg::idx_t        nx;

  assign can_load  = !out_full || !rsp_stall;
  assign proc      = req_full && can_load;
  assign req_stall = req_full && !can_load;

  assign rsp_valid       = out_full;
  assign picked          = out_picked;
  assign chosen_index    = out_index;
  assign chosen_priority = out_prio;

  assign push_ok = (req_idx != '0) &&
                   ({1'b0, req_idx} < (IDX_W + 1)'(prqs_pkg::TASK_SLOTS)) &&
                   ({1'b0, req_prio} < (PRIO_W + 1)'(prqs_pkg::PRIORITY_LEVELS));

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      head_next[l]  = head[l];
      tail_next[l]  = tail[l];
      hlink_next[l] = hlink[l];
    end
    if (pend) begin
      hlink_next[pend_lv] = fwd_hit ? fwd_val : (rd_valid ? rd_data : '0);
    end
    mask_next      = mask;
    act_valid_next = act_valid;
    act_index_next = act_index;
    act_prio_next  = act_prio;
    act_link_next  = act_link;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    clr_en     = 1'b0;
    clr_addr   = '0;
    rd_issue   = 1'b0;
    rd_addr    = '0;
    rd_lv      = '0;
    res_picked = 1'b0;
    res_index  = '0;
    res_prio   = '0;
    enq_idx    = req_idx;
    enq_lv     = req_prio;
    tl         = '0;
    lv         = '0;
    hd         = '0;
    nx         = '0;

    if (proc) begin
      unique case (req_op)
        prqs_pkg::OP_PUSH, prqs_pkg::OP_SCHEDULE: begin
          if (req_op == prqs_pkg::OP_SCHEDULE) begin
            enq_idx = act_index;
            enq_lv  = act_prio;
          end
          // Append to the tail; a schedule re-queues the active task first.
          if ((req_op == prqs_pkg::OP_PUSH && push_ok) ||
              (req_op == prqs_pkg::OP_SCHEDULE && act_valid)) begin
            tl = tail_next[enq_lv];
            if (tl != '0) begin
              wr_en   = 1'b1;
              wr_addr = tl;
              wr_data = enq_idx;
              for (int l = 0; l < NUM_LEVELS; l++) begin
                if (head_next[l] == tl) begin
                  hlink_next[l] = enq_idx;
                end
              end
              if (act_index == tl) begin
                act_link_next = enq_idx;
              end
            end else begin
              head_next[enq_lv] = enq_idx;
              if (req_op == prqs_pkg::OP_SCHEDULE) begin
                hlink_next[enq_lv] = act_link;
              end else begin
                rd_issue = 1'b1;
                rd_addr  = enq_idx;
                rd_lv    = enq_lv;
              end
            end
            tail_next[enq_lv] = enq_idx;
            mask_next[enq_lv] = 1'b1;
          end

          // Pop the head of the most urgent non-empty level.
          if (req_op == prqs_pkg::OP_SCHEDULE && mask_next != '0) begin
            for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
              if (mask_next[l]) begin
                lv = PRIO_W'(l);
              end
            end
            hd            = head_next[lv];
            nx            = hlink_next[lv];
            head_next[lv] = nx;
            clr_en        = 1'b1;
            clr_addr      = hd;
            for (int l = 0; l < NUM_LEVELS; l++) begin
              if (head_next[l] == hd) begin
                hlink_next[l] = '0;
              end
            end
            if (nx == '0) begin
              tail_next[lv] = '0;
              mask_next[lv] = 1'b0;
            end else begin
              rd_issue = 1'b1;
              rd_addr  = nx;
              rd_lv    = lv;
            end
            act_valid_next = 1'b1;
            act_index_next = hd;
            act_prio_next  = lv;
            act_link_next  = '0;
            res_picked     = 1'b1;
            res_index      = hd;
            res_prio       = lv;
          end
        end
        prqs_pkg::OP_DROP: begin
          act_valid_next = 1'b0;
          act_index_next = '0;
          act_prio_next  = '0;
        end
        default: begin
        end
      endcase
    end

    // The memory returns the entry as it was before this cycle's writes; the clear comes last.
    if (clr_en && clr_addr == rd_addr) begin
      fwd_hit_next = 1'b1;
      fwd_val_next = '0;
    end else if (wr_en && wr_addr == rd_addr) begin
      fwd_hit_next = 1'b1;
      fwd_val_next = wr_data;
    end else begin
      fwd_hit_next = 1'b0;
      fwd_val_next = '0;
    end
  end

  // A clear of the same entry in the same cycle wins over the write.
  always_comb begin
    link_valid_next = link_valid;
    if (wr_en) begin
      link_valid_next[wr_addr] = 1'b1;
    end
    if (clr_en) begin
      link_valid_next[clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full   <= 1'b0;
      out_full   <= 1'b0;
      mask       <= '0;
      act_valid  <= 1'b0;
      act_index  <= '0;
      act_prio   <= '0;
      act_link   <= '0;
      link_valid <= '0;
      pend       <= 1'b0;
      pend_lv    <= '0;
      fwd_hit    <= 1'b0;
      fwd_val    <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        hlink[l] <= '0;
      end
    end else begin
      if (!req_stall) begin
        req_full <= req_valid;
      end
      if (can_load) begin
        out_full <= proc;
      end
      mask      <= mask_next;
      act_valid <= act_valid_next;
      act_index <= act_index_next;
      act_prio  <= act_prio_next;
      act_link  <= act_link_next;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l]  <= head_next[l];
        tail[l]  <= tail_next[l];
        hlink[l] <= hlink_next[l];
      end
      link_valid <= link_valid_next;
      pend    <= rd_issue;
      pend_lv <= rd_lv;
      fwd_hit <= fwd_hit_next;
      fwd_val <= fwd_val_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      req_op   <= opcode;
      req_idx  <= task_index;
      req_prio <= priority_req;
    end
    if (can_load) begin
      out_picked <= res_picked;
      out_index  <= res_index;
      out_prio   <= res_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    rd_data  <= link_mem[rd_addr];
    rd_valid <= link_valid[rd_addr];
  end

endmodule

[tb/prqs_checker.sv]
module prqs_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  logic [1:0]      opcode,
  input  prqs_pkg::idx_t  task_index,
  input  prqs_pkg::prio_t priority_req,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  logic            picked,
  input  prqs_pkg::idx_t  chosen_index,
  input  prqs_pkg::prio_t chosen_priority,
  output int              mismatches,
  output int              pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            picked;
    prqs_pkg::idx_t  index;
    prqs_pkg::prio_t level;
  } pick_t;

  // Shadow copy of the ready queues and of the running task.
  prqs_pkg::idx_t  head_of [prqs_pkg::NUM_LEVELS];
  prqs_pkg::idx_t  tail_of [prqs_pkg::NUM_LEVELS];
  prqs_pkg::idx_t  link_of [prqs_pkg::NUM_SLOTS];
  logic [31:0]     ready_mask;
  logic            run_valid;
  prqs_pkg::idx_t  run_task;
  prqs_pkg::prio_t run_level;

  pick_t expected_picks[$];

  function automatic void clear_queues();
    for (int i = 0; i < prqs_pkg::NUM_LEVELS; i++) begin
      head_of[i] = '0;
      tail_of[i] = '0;
    end
    for (int i = 0; i < prqs_pkg::NUM_SLOTS; i++) begin
      link_of[i] = '0;
    end
    ready_mask = '0;
    run_valid  = 1'b0;
    run_task   = '0;
    run_level  = '0;
  endfunction

  function automatic void link_task(prqs_pkg::prio_t lvl, prqs_pkg::idx_t t);
    if (tail_of[lvl] != '0) begin
      link_of[tail_of[lvl]] = t;
    end else begin
      head_of[lvl] = t;
    end
    tail_of[lvl]    = t;
    ready_mask[lvl] = 1'b1;
  endfunction

  function automatic prqs_pkg::idx_t unlink_head(prqs_pkg::prio_t lvl);
    prqs_pkg::idx_t hd;
    prqs_pkg::idx_t nx;
    hd          = head_of[lvl];
    nx          = link_of[hd];
    head_of[lvl] = nx;
    link_of[hd]  = '0;
    if (nx == '0) begin
      tail_of[lvl]    = '0;
      ready_mask[lvl] = 1'b0;
    end
    return hd;
  endfunction

  function automatic pick_t step_scheduler(logic [1:0] op, prqs_pkg::idx_t idx,
                                           prqs_pkg::prio_t lvl);
    pick_t res;
    int    top_level;
    res = '0;
    case (op)
      prqs_pkg::OP_PUSH: begin
        if (idx != '0) link_task(lvl, idx);
      end
      prqs_pkg::OP_SCHEDULE: begin
        // The running task goes back to the tail of its own level first.
        if (run_valid) link_task(run_level, run_task);
        if (ready_mask != '0) begin
          top_level = 0;
          while (!ready_mask[top_level]) top_level++;
          res.picked = 1'b1;
          res.index  = unlink_head(prqs_pkg::prio_t'(top_level));
          res.level  = prqs_pkg::prio_t'(top_level);
          run_valid  = 1'b1;
          run_task   = res.index;
          run_level  = res.level;
        end
      end
      prqs_pkg::OP_DROP: begin
        run_valid = 1'b0;
        run_task  = '0;
        run_level = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin : watch
    pick_t want;
    if (rst) begin
      clear_queues();
      expected_picks.delete();
      pending <= 0;
    end else begin
      // Responses are matched before new requests, as a response always
      // belongs to a word accepted at an earlier edge.
      if (rsp_valid && !rsp_stall) begin
        if (expected_picks.size() == 0) begin
          mismatches++;
          $display("%0t: response with nothing outstanding: picked %0d index %0d priority %0d",
                   $time, picked, chosen_index, chosen_priority);
        end else begin
          want = expected_picks.pop_front();
          if (picked !== want.picked) note_mismatch("picked", want.picked, picked);
          if (chosen_index !== want.index)
            note_mismatch("chosen_index", want.index, chosen_index);
          if (chosen_priority !== want.level)
            note_mismatch("chosen_priority", want.level, chosen_priority);
        end
      end
      if (req_valid && !req_stall) begin
        expected_picks.push_back(step_scheduler(opcode, task_index, priority_req));
      end
      pending <= expected_picks.size();
    end
  end

endmodule

[tb/tb_priority_ready_queue_scheduler_core.sv]
module tb_priority_ready_queue_scheduler_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         ITEM_GOAL  = 2000;
  localparam int         IDLE_LIMIT = 2000;

  logic            clk = 1'b0;
  logic            rst;
  logic            req_valid;
  logic            req_stall;
  logic [1:0]      opcode;
  prqs_pkg::idx_t  task_index;
  prqs_pkg::prio_t priority_req;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  logic            picked;
  prqs_pkg::idx_t  chosen_index;
  prqs_pkg::prio_t chosen_priority;

  int mismatches;
  int pending;
  int words_sent   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int stall_clock  = 0;
  int stall_mode   = 0;

  always #5 clk = ~clk;

  priority_ready_queue_scheduler_core u_top (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .opcode          (opcode),
    .task_index      (task_index),
    .priority_req    (priority_req),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .picked          (picked),
    .chosen_index    (chosen_index),
    .chosen_priority (chosen_priority)
  );

  prqs_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .opcode          (opcode),
    .task_index      (task_index),
    .priority_req    (priority_req),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .picked          (picked),
    .chosen_index    (chosen_index),
    .chosen_priority (chosen_priority),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  // The response side switches its stall behaviour among four randomly drawn modes.
  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    if (stall_clock % 256 == 255) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= stall_clock[3];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_priority_ready_queue_scheduler_core failed");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] op, input prqs_pkg::idx_t idx,
                           input prqs_pkg::prio_t lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid    <= 1'b1;
    opcode       <= op;
    task_index   <= idx;
    priority_req <= lvl;
    do @(posedge clk); while (req_stall);
    if (!(op == OP_UNUSED || (op == prqs_pkg::OP_PUSH && idx == '0))) words_sent++;
  endtask

  task automatic send_control(input logic [1:0] op);
    send_word(op, prqs_pkg::idx_t'($urandom), prqs_pkg::prio_t'($urandom));
  endtask

  // One episode pushes fresh tasks into a band of levels, mixed with schedules, drops, ignored
  // words and, in some episodes, repeated pushes, then drains the levels by dropping and scheduling.
  task automatic run_episode();
    prqs_pkg::idx_t pool[255];
    prqs_pkg::idx_t tmp;
    int   n_tasks;
    int   pushed;
    int   span;
    int   base;
    int   j;
    int   r;
    logic broken;
    for (int i = 0; i < 255; i++) pool[i] = prqs_pkg::idx_t'(i + 1);
    for (int i = 254; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    n_tasks = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    broken  = ($urandom_range(0, 4) == 0);
    span    = 1 << $urandom_range(0, 5);
    base    = $urandom_range(0, prqs_pkg::NUM_LEVELS - span);
    pushed  = 0;
    while (pushed < n_tasks) begin
      r = $urandom_range(0, 19);
      if (r < 10) begin
        send_word(prqs_pkg::OP_PUSH, pool[pushed],
                  prqs_pkg::prio_t'(base + $urandom_range(0, span - 1)));
        pushed++;
      end else if (r < 16) begin
        send_control(prqs_pkg::OP_SCHEDULE);
      end else if (r < 18) begin
        send_control(prqs_pkg::OP_DROP);
      end else if (r == 18) begin
        if ($urandom_range(0, 1) == 0) begin
          send_word(prqs_pkg::OP_PUSH, '0, prqs_pkg::prio_t'($urandom));
        end else begin
          send_control(OP_UNUSED);
        end
      end else if (broken) begin
        // A task that may already be queued or running is pushed again.
        send_word(prqs_pkg::OP_PUSH, pool[$urandom_range(0, pushed)],
                  prqs_pkg::prio_t'($urandom));
      end else begin
        send_control(prqs_pkg::OP_SCHEDULE);
      end
    end
    repeat (n_tasks + 2) begin
      send_control(prqs_pkg::OP_DROP);
      send_control(prqs_pkg::OP_SCHEDULE);
    end
  endtask

  initial begin
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    opcode       <= prqs_pkg::OP_PUSH;
    task_index   <= '0;
    priority_req <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty scheduler, drop with nothing running, ignored words.
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_DROP, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_PUSH, 8'd0, 5'd7);
    send_word(OP_UNUSED, 8'd255, 5'd31);
    // Extreme indices and levels, two tasks sharing the most urgent level 0.
    send_word(prqs_pkg::OP_PUSH, 8'd255, 5'd31);
    send_word(prqs_pkg::OP_PUSH, 8'd1, 5'd0);
    send_word(prqs_pkg::OP_PUSH, 8'd170, 5'd21);
    send_word(prqs_pkg::OP_PUSH, 8'd85, 5'd10);
    send_word(prqs_pkg::OP_PUSH, 8'd2, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    // The running task is pushed again at another level.
    send_word(prqs_pkg::OP_PUSH, 8'd1, 5'd10);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_DROP, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_DROP, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_DROP, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_DROP, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_DROP, 8'd0, 5'd0);
    send_word(prqs_pkg::OP_SCHEDULE, 8'd0, 5'd0);

    while (words_sent < ITEM_GOAL) run_episode();

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_priority_ready_queue_scheduler_core passed");
    end else begin
      $display("tb_priority_ready_queue_scheduler_core failed");
    end
    $finish;
  end

endmodule
